@@ rtl/nite_pkg.sv @@
// ----------------------------------------------------------------------------
// nite_pkg
// Shared types and constants for the node id table engine.
// ----------------------------------------------------------------------------
package nite_pkg;

  localparam int ID_W         = 8;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 8;
  localparam int MAX_PAY_W    = 64;
  localparam int MAX_NODE_ID  = 254;
  localparam int DEF_DEPTH    = 254;
  localparam int DEF_PAY_W    = 32;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_LOOKUP     = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

@@ rtl/node_id_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// node_id_table_engine_top
// Packed node table: register, unregister, lookup and read by slot.
// Invalid-id register and out-of-range read go from S_IDLE straight to S_RESP,
//   read by slot through S_FETCH; scans check one stored id per cycle, then a
//   lookup hit goes through S_FETCH, an unregister hit through S_LAST and S_MOVE.
// S_RESP raises out_valid. One command at a time; the next in beat is taken in
//   the cycle after the out beat is loaded.
// Reset empties the table at once (count to zero); no memory clearing pass.
// ----------------------------------------------------------------------------
module node_id_table_engine_top #(
  parameter int TABLE_DEPTH   = nite_pkg::DEF_DEPTH,
  parameter int PAYLOAD_WIDTH = nite_pkg::DEF_PAY_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [nite_pkg::ID_W-1:0]   in_node_id,
  input  logic [7:0]                  in_slot_index,
  input  logic [nite_pkg::DATA_W-1:0] in_entry_payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [nite_pkg::ID_W-1:0]   out_found_id,
  output logic [nite_pkg::DATA_W-1:0] out_found_payload,
  output logic [nite_pkg::COUNT_W-1:0] out_entry_count
);
  import nite_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LAST, S_MOVE, S_FETCH, S_RESP
  } state_t;

  state_t                   state_r;
  cmd_t                     cmd_r;
  logic [ID_W-1:0]          id_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         ptr_r;
  logic                     chk_vld_r;
  logic [IDX_W-1:0]         chk_ptr_r;
  logic [IDX_W-1:0]         slot_r;
  status_t                  res_status_r;
  logic                     use_rd_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [ID_W-1:0]          out_id_r;
  logic [DATA_W-1:0]        out_pay_r;
  logic [COUNT_W-1:0]       out_cnt_r;

  logic [ID_W-1:0]          id_mem [TABLE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [TABLE_DEPTH];
  logic [ID_W-1:0]          id_rd_r;
  logic [PAYLOAD_WIDTH-1:0] pay_rd_r;

  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [ID_W-1:0]          wr_id;
  logic [PAYLOAD_WIDTH-1:0] wr_pay;
  logic [CNT_W-1:0]         last_w;
  logic                     hit;
  logic                     scan_done;
  logic                     is_full;
  logic                     in_acc;
  logic                     out_free;
  logic [MAX_PAY_W-1:0]     in_pay_ext;
  logic [MAX_PAY_W-1:0]     rd_pay_ext;
  cmd_t                     in_cmd;

  assign in_cmd     = cmd_t'(in_command);
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign last_w     = cnt_r - CNT_W'(1);
  assign hit        = chk_vld_r && (id_rd_r == id_r);
  assign scan_done  = !chk_vld_r && (ptr_r == cnt_r);
  assign is_full    = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign in_pay_ext = MAX_PAY_W'(in_entry_payload);
  assign rd_pay_ext = MAX_PAY_W'(pay_rd_r);

  always_comb begin
    rd_addr = slot_r;
    wr_en   = 1'b0;
    wr_addr = chk_ptr_r;
    wr_id   = id_r;
    wr_pay  = pay_r;
    unique case (state_r)
      S_SCAN: begin
        rd_addr = ptr_r[IDX_W-1:0];
        if (cmd_r == CMD_REGISTER) begin
          if (hit) begin
            wr_en = 1'b1;
          end else if (scan_done && !is_full) begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[IDX_W-1:0];
          end
        end
      end
      S_LAST: begin
        rd_addr = last_w[IDX_W-1:0];
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = slot_r;
        wr_id   = id_rd_r;
        wr_pay  = pay_rd_r;
      end
      S_IDLE, S_FETCH, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      pay_mem[wr_addr] <= wr_pay;
    end
    id_rd_r  <= id_mem[rd_addr];
    pay_rd_r <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r     <= in_cmd;
            id_r      <= in_node_id;
            pay_r     <= in_pay_ext[PAYLOAD_WIDTH-1:0];
            ptr_r     <= '0;
            chk_vld_r <= 1'b0;
            use_rd_r  <= 1'b0;
            if (in_cmd == CMD_REGISTER &&
                (in_node_id == '0 || in_node_id > ID_W'(MAX_NODE_ID))) begin
              res_status_r <= ST_INVALID;
              state_r      <= S_RESP;
            end else if (in_cmd == CMD_READ) begin
              if (in_slot_index < 8'(cnt_r)) begin
                slot_r  <= in_slot_index[IDX_W-1:0];
                state_r <= S_FETCH;
              end else begin
                res_status_r <= ST_NOT_FOUND;
                state_r      <= S_RESP;
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld_r <= (ptr_r != cnt_r);
          chk_ptr_r <= ptr_r[IDX_W-1:0];
          if (ptr_r != cnt_r) begin
            ptr_r <= ptr_r + CNT_W'(1);
          end
          if (hit) begin
            slot_r <= chk_ptr_r;
            unique case (cmd_r)
              CMD_REGISTER: begin
                res_status_r <= ST_OK;
                state_r      <= S_RESP;
              end
              CMD_UNREGISTER: begin
                state_r <= S_LAST;
              end
              default: begin
                state_r <= S_FETCH;
              end
            endcase
          end else if (scan_done) begin
            if (cmd_r == CMD_REGISTER) begin
              if (is_full) begin
                res_status_r <= ST_FULL;
              end else begin
                res_status_r <= ST_OK;
                cnt_r        <= cnt_r + CNT_W'(1);
              end
            end else begin
              res_status_r <= ST_NOT_FOUND;
            end
            state_r <= S_RESP;
          end
        end
        S_LAST: begin
          state_r <= S_MOVE;
        end
        S_MOVE: begin
          cnt_r        <= last_w;
          res_status_r <= ST_OK;
          state_r      <= S_RESP;
        end
        S_FETCH: begin
          use_rd_r     <= 1'b1;
          res_status_r <= ST_OK;
          state_r      <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= use_rd_r ? id_rd_r : '0;
            out_pay_r    <= use_rd_r ? rd_pay_ext[DATA_W-1:0] : '0;
            out_cnt_r    <= COUNT_W'(cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_id      = out_id_r;
  assign out_found_payload = out_pay_r;
  assign out_entry_count   = out_cnt_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1) ||
                      cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_id_r == '0 && out_pay_r == '0))
    else $error("failed command returned entry data");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");

  a_write_scope: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_MOVE || (state_r == S_SCAN && cmd_r == CMD_REGISTER)))
    else $error("table written outside register or move");
`endif

endmodule
